FILE: rtl/rem_pkg.sv
// Package for the refinement error marker: register indexes, shape codes
// and the configuration port widths. No dependencies.
`default_nettype none
package rem_pkg;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [CsrIdxWidth-1:0] RegShape   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegScaleX  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegScaleY  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegScaleZ  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegEpsilon = 3'd4;
   localparam logic [CsrIdxWidth-1:0] RegCenterX = 3'd5;
   localparam logic [CsrIdxWidth-1:0] RegCenterY = 3'd6;

   localparam logic [1:0] ShapeSphere = 2'd0;
   localparam logic [1:0] ShapeCube   = 2'd1;
   localparam logic [1:0] ShapeBoxes  = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/refinement_error_marker_core.sv
// Refinement error marker: radius by shape, floor, reciprocal, saturation.
// Depends on rem_pkg.
//
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_pos_x/y/z
// rsp     | out       | rsp_valid, rsp_ready, rsp_error_value, rsp_saturated
// csr     | in        | csr_we, csr_index, csr_wdata
//
// One item per cycle while rsp is not stalled. Items pass through stages A to E,
// the one-bit-per-stage square root, the floor stage, the one-bit-per-stage
// reciprocal divider and the output register. Synchronous reset clears valids
// and sets the CSRs to defaults. A stall at rsp freezes the whole pipeline.
`default_nettype none
module refinement_error_marker_core
   import rem_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [COORD_WIDTH-1:0]  req_pos_x,
   input  wire logic [COORD_WIDTH-1:0]  req_pos_y,
   input  wire logic [COORD_WIDTH-1:0]  req_pos_z,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [31:0]                  rsp_error_value,
   output logic                         rsp_saturated,
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);
   localparam int CW = COORD_WIDTH;
   localparam int DW = ((CW > 32) ? CW : 32) + 1;
   localparam int MW = CW - 1;
   localparam int PW = DW + 16;
   localparam int H  = (MW + 1) / 2;
   localparam int L  = MW - H;
   localparam int SW = 2 * MW + 2;
   localparam int RW = (MW > 31) ? MW : 31;
   localparam int QB = 2 * FRAC_BITS + 1;
   localparam int QW = (QB > 33) ? QB : 33;
   localparam int NS = 5 + MW + 1 + QB + 1;

   logic [1:0]  shape_ff;
   logic [15:0] scale_x_ff, scale_y_ff, scale_z_ff;
   logic [30:0] eps_ff;
   logic [31:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff   <= ShapeSphere;
         scale_x_ff <= 16'd1;
         scale_y_ff <= 16'd1;
         scale_z_ff <= 16'd1;
         eps_ff     <= 31'd66;
         cx_ff      <= 32'd327680;
         cy_ff      <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            RegShape:   shape_ff   <= csr_wdata[1:0];
            RegScaleX:  scale_x_ff <= csr_wdata[15:0];
            RegScaleY:  scale_y_ff <= csr_wdata[15:0];
            RegScaleZ:  scale_z_ff <= csr_wdata[15:0];
            RegEpsilon: eps_ff     <= csr_wdata[30:0];
            RegCenterX: cx_ff      <= csr_wdata[31:0];
            RegCenterY: cy_ff      <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic [NS-1:0] v_ff;
   assign adv       = !v_ff[NS-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], req_valid};
      end
   end

   // stage A: magnitudes of position and offsets from both centres
   logic signed [DW-1:0] px, py, pz, cxe, cye;
   logic [DW-1:0] a_in [7];
   logic [DW-1:0] a_mag_ff [7];
   assign px  = {{(DW-CW){req_pos_x[CW-1]}}, req_pos_x};
   assign py  = {{(DW-CW){req_pos_y[CW-1]}}, req_pos_y};
   assign pz  = {{(DW-CW){req_pos_z[CW-1]}}, req_pos_z};
   assign cxe = {{(DW-32){cx_ff[31]}}, cx_ff};
   assign cye = {{(DW-32){cy_ff[31]}}, cy_ff};
   assign a_in[0] = px;
   assign a_in[1] = py;
   assign a_in[2] = pz;
   assign a_in[3] = px - cxe;
   assign a_in[4] = py - cye;
   assign a_in[5] = px + cxe;
   assign a_in[6] = py + cye;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 7; i++) begin
            a_mag_ff[i] <= a_in[i][DW-1] ? DW'(0) - a_in[i] : a_in[i];
         end
      end
   end

   // stage B: scale and clip
   logic [15:0]   b_scale [7];
   logic [PW-1:0] b_prod [7];
   logic [MW-1:0] b_mag_ff [7];
   logic [6:0]    b_sat_ff;
   assign b_scale[0] = scale_x_ff;
   assign b_scale[1] = scale_y_ff;
   assign b_scale[2] = scale_z_ff;
   assign b_scale[3] = scale_x_ff;
   assign b_scale[4] = scale_y_ff;
   assign b_scale[5] = scale_x_ff;
   assign b_scale[6] = scale_y_ff;

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         b_prod[i] = {{(PW-DW){1'b0}}, a_mag_ff[i]} * {{(PW-16){1'b0}}, b_scale[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 7; i++) begin
            b_sat_ff[i] <= |b_prod[i][PW-1:MW];
            b_mag_ff[i] <= (|b_prod[i][PW-1:MW]) ? {MW{1'b1}} : b_prod[i][MW-1:0];
         end
      end
   end

   // stage C: max-norm radii and square partial products
   logic [MW-1:0] c_m1, c_d1, c_d2, c_cube, c_box;
   logic [MW-1:0] c_alt_ff;
   logic          c_sph_ff, c_flag_ff;
   logic [2*L-1:0] c_hh_ff [3];
   logic [L+H-1:0] c_hl_ff [3];
   logic [2*H-1:0] c_ll_ff [3];

   always_comb begin
      c_m1   = (b_mag_ff[0] > b_mag_ff[1]) ? b_mag_ff[0] : b_mag_ff[1];
      c_cube = (c_m1 > b_mag_ff[2]) ? c_m1 : b_mag_ff[2];
      c_d1   = (b_mag_ff[3] > b_mag_ff[4]) ? b_mag_ff[3] : b_mag_ff[4];
      c_d1   = (c_d1 > b_mag_ff[2]) ? c_d1 : b_mag_ff[2];
      c_d2   = (b_mag_ff[5] > b_mag_ff[6]) ? b_mag_ff[5] : b_mag_ff[6];
      c_d2   = (c_d2 > b_mag_ff[2]) ? c_d2 : b_mag_ff[2];
      c_box  = (c_d1 < c_d2) ? c_d1 : c_d2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         case (shape_ff)
            ShapeCube: begin
               c_sph_ff  <= 1'b0;
               c_alt_ff  <= c_cube;
               c_flag_ff <= |b_sat_ff[2:0];
            end
            ShapeBoxes: begin
               c_sph_ff  <= 1'b0;
               c_alt_ff  <= c_box;
               c_flag_ff <= |b_sat_ff[6:2];
            end
            default: begin
               c_sph_ff  <= 1'b1;
               c_alt_ff  <= c_cube;
               c_flag_ff <= |b_sat_ff[2:0];
            end
         endcase
         for (int i = 0; i < 3; i++) begin
            c_hh_ff[i] <= {{L{1'b0}}, b_mag_ff[i][MW-1:H]} * {{L{1'b0}}, b_mag_ff[i][MW-1:H]};
            c_hl_ff[i] <= {{H{1'b0}}, b_mag_ff[i][MW-1:H]} * {{L{1'b0}}, b_mag_ff[i][H-1:0]};
            c_ll_ff[i] <= {{H{1'b0}}, b_mag_ff[i][H-1:0]} * {{H{1'b0}}, b_mag_ff[i][H-1:0]};
         end
      end
   end

   // stage D: per-axis squares
   logic [2*MW-1:0] d_sq_ff [3];
   logic [MW-1:0]   d_alt_ff;
   logic            d_sph_ff, d_flag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d_alt_ff  <= c_alt_ff;
         d_sph_ff  <= c_sph_ff;
         d_flag_ff <= c_flag_ff;
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= ({{(2*MW-2*L){1'b0}}, c_hh_ff[i]} << (2*H))
                        + ({{(2*MW-L-H){1'b0}}, c_hl_ff[i]} << (H+1))
                        + {{(2*MW-2*H){1'b0}}, c_ll_ff[i]};
         end
      end
   end

   // stage E: sum of squares feeds the root pipeline
   logic [SW-1:0] e_sum;
   logic [SW-1:0] s_rem [MW+1];
   logic [MW-1:0] s_root [MW+1];
   logic [MW-1:0] s_alt [MW+1];
   logic          s_sph [MW+1];
   logic          s_flag [MW+1];
   logic          s_sqs [MW+1];
   assign e_sum = {2'b00, d_sq_ff[0]} + {2'b00, d_sq_ff[1]} + {2'b00, d_sq_ff[2]};

   always_ff @(posedge clock) begin
      if (adv) begin
         s_rem[0]  <= e_sum;
         s_root[0] <= '0;
         s_alt[0]  <= d_alt_ff;
         s_sph[0]  <= d_sph_ff;
         s_flag[0] <= d_flag_ff;
         s_sqs[0]  <= |e_sum[SW-1:2*MW];
      end
   end

   for (genvar k = 0; k < MW; k++) begin : g_root
      localparam int B = MW - 1 - k;
      logic [SW-1:0] trial;
      assign trial = ({{(SW-MW){1'b0}}, s_root[k]} << (B+1)) | (SW'(1) << (2*B));
      always_ff @(posedge clock) begin
         if (adv) begin
            s_alt[k+1]  <= s_alt[k];
            s_sph[k+1]  <= s_sph[k];
            s_flag[k+1] <= s_flag[k];
            s_sqs[k+1]  <= s_sqs[k];
            if (s_rem[k] >= trial) begin
               s_rem[k+1]  <= s_rem[k] - trial;
               s_root[k+1] <= s_root[k] | (MW'(1) << B);
            end else begin
               s_rem[k+1]  <= s_rem[k];
               s_root[k+1] <= s_root[k];
            end
         end
      end
   end

   // floor stage, then restoring divide of 2^(2*FRAC_BITS)
   logic [MW-1:0] f_r;
   logic [RW-1:0] f_rf, f_re, f_ee;
   logic [RW:0]   q_rem [QB+1];
   logic [QB-1:0] q_quo [QB+1];
   logic [RW-1:0] q_div [QB+1];
   logic          q_flag [QB+1];

   always_comb begin
      if (s_sph[MW]) begin
         f_r = s_sqs[MW] ? {MW{1'b1}} : s_root[MW];
      end else begin
         f_r = s_alt[MW];
      end
      f_re = RW'(f_r);
      f_ee = RW'(eps_ff);
      f_rf = (f_re > f_ee) ? f_re : f_ee;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_rem[0]  <= '0;
         q_quo[0]  <= '0;
         q_div[0]  <= f_rf;
         q_flag[0] <= s_flag[MW] | (s_sph[MW] & s_sqs[MW]);
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [RW:0] shifted;
      logic        ge;
      assign shifted = {q_rem[j][RW-1:0], (j == 0) ? 1'b1 : 1'b0};
      assign ge      = shifted >= {1'b0, q_div[j]};
      always_ff @(posedge clock) begin
         if (adv) begin
            q_div[j+1]  <= q_div[j];
            q_flag[j+1] <= q_flag[j];
            q_rem[j+1]  <= ge ? shifted - {1'b0, q_div[j]} : shifted;
            q_quo[j+1]  <= {q_quo[j][QB-2:0], ge};
         end
      end
   end

   // output register
   logic [QW-1:0] o_q;
   logic          o_over;
   assign o_q    = QW'(q_quo[QB]);
   assign o_over = (q_div[QB] == '0) || (|o_q[QW-1:32]);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_error_value <= o_over ? 32'hFFFF_FFFF : o_q[31:0];
         rsp_saturated   <= q_flag[QB] | o_over;
      end
   end
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for refinement_error_marker_core: drives corner and random
// positions through the shape modes and checks error values and clip flags
// against a predictor. Depends on rem_pkg and the core RTL.
`default_nettype none
module tb_top;
   import rem_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ShapeSpare = 2'd3;
   localparam logic [63:0] MagMax = 64'h7FFF_FFFF;

   typedef struct {
      logic signed [31:0] x, y, z;
   } point_type;
   typedef struct {
      logic [31:0] value;
      logic        clip;
   } marker_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [31:0] rsp_error_value;
   logic rsp_saturated;
   logic csr_we = 0;
   logic [CsrIdxWidth-1:0] csr_index = 0;
   logic [CsrDataWidth-1:0] csr_wdata = 0;

   point_type  points_pending[$];
   marker_type markers_due[$];
   bit      req_taken = 0;
   int      mismatches = 0;
   int      cycle_count = 0;

   logic [1:0]         shape_cfg = ShapeSphere;
   logic [15:0]        scale_cfg[3] = '{16'd1, 16'd1, 16'd1};
   logic [30:0]        eps_cfg = 31'd66;
   logic signed [31:0] cx_cfg = 32'sd327680, cy_cfg = 32'sd0;
   bit                 clip_acc;

   refinement_error_marker_core u_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   function automatic logic [63:0] scaled_mag(logic signed [63:0] v, logic [15:0] s);
      logic [63:0] m;
      m = (v < 0) ? -v : v;
      m = m * s;
      if (m > MagMax) begin
         clip_acc = 1;
         m = MagMax;
      end
      return m;
   endfunction

   function automatic logic [63:0] max3(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [63:0] m;
      m = a > b ? a : b;
      return m > c ? m : c;
   endfunction

   function automatic marker_type predict_marker(point_type p);
      logic signed [63:0] x, y, z, cx, cy;
      logic [63:0] a, b, c, d1, d2, r, rf, q, cand;
      logic [127:0] sum;
      marker_type res;
      clip_acc = 0;
      x = p.x; y = p.y; z = p.z; cx = cx_cfg; cy = cy_cfg;
      if (shape_cfg == ShapeCube) begin
         r = max3(scaled_mag(x, scale_cfg[0]), scaled_mag(y, scale_cfg[1]),
                  scaled_mag(z, scale_cfg[2]));
      end else if (shape_cfg == ShapeBoxes) begin
         c = scaled_mag(z, scale_cfg[2]);
         d1 = max3(scaled_mag(x - cx, scale_cfg[0]), scaled_mag(y - cy, scale_cfg[1]), c);
         d2 = max3(scaled_mag(x + cx, scale_cfg[0]), scaled_mag(y + cy, scale_cfg[1]), c);
         r = d1 < d2 ? d1 : d2;
      end else begin
         a = scaled_mag(x, scale_cfg[0]);
         b = scaled_mag(y, scale_cfg[1]);
         c = scaled_mag(z, scale_cfg[2]);
         sum = 128'(a) * a + 128'(b) * b + 128'(c) * c;
         r = 0;
         if (sum >= (128'd1 << 62)) begin
            clip_acc = 1;
            r = MagMax;
         end else begin
            for (int i = 30; i >= 0; i--) begin
               cand = r | (64'd1 << i);
               if (128'(cand * cand) <= sum) r = cand;
            end
         end
      end
      rf = r > eps_cfg ? r : 64'(eps_cfg);
      if (rf == 0) begin
         q = 64'hFFFF_FFFF;
         clip_acc = 1;
      end else begin
         q = (64'd1 << 32) / rf;
         if (q > 64'hFFFF_FFFF) begin
            q = 64'hFFFF_FFFF;
            clip_acc = 1;
         end
      end
      res.value = q[31:0];
      res.clip = clip_acc;
      return res;
   endfunction

   // driver
   always @(negedge clock) begin
      bit quiet;
      cycle_count++;
      quiet = cycle_count > 3000 && cycle_count < 9000;
      if (reset) begin
         req_valid <= 0;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= quiet || $urandom_range(99) >= 20;
         if (!req_valid || req_taken) begin
            req_taken = 0;
            if (points_pending.size() > 0 && (quiet || $urandom_range(99) >= 20)) begin
               req_valid <= 1;
               req_pos_x <= points_pending[0].x;
               req_pos_y <= points_pending[0].y;
               req_pos_z <= points_pending[0].z;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      marker_type want;
      if (!reset) begin
         if (req_valid && req_ready && !req_taken) begin
            markers_due.push_back(predict_marker(points_pending[0]));
            void'(points_pending.pop_front());
            req_taken = 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (markers_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item: %h %b",
                                              rsp_error_value, rsp_saturated);
            end else begin
               want = markers_due.pop_front();
               if (rsp_error_value !== want.value || rsp_saturated !== want.clip) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h %b, got %h %b", want.value,
                              want.clip, rsp_error_value, rsp_saturated);
               end
            end
         end
      end
   end

   task automatic write_reg(logic [CsrIdxWidth-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         RegShape:   shape_cfg = data[1:0];
         RegScaleX:  scale_cfg[0] = data[15:0];
         RegScaleY:  scale_cfg[1] = data[15:0];
         RegScaleZ:  scale_cfg[2] = data[15:0];
         RegEpsilon: eps_cfg = data[30:0];
         RegCenterX: cx_cfg = data;
         RegCenterY: cy_cfg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic drain;
      while (points_pending.size() > 0 || markers_due.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
         2: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
         3: return $urandom_range(255) - 128;
         default: begin
            case ($urandom_range(4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               3: return 32'd1;
               default: return 32'd0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_scale();
      case ($urandom_range(5))
         0: return 1;
         1: return 16'hFFFF;
         2: return 0;
         3: return $urandom;
         default: return $urandom_range(8, 1);
      endcase
   endfunction

   function automatic logic [31:0] rand_eps();
      case ($urandom_range(4))
         0: return 1;
         1: return 32'h7FFF_FFFF;
         2: return 0;
         3: return $urandom & 32'h7FFF_FFFF;
         default: return $urandom_range(1000, 1);
      endcase
   endfunction

   task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      point_type p;
      p.x = x; p.y = y; p.z = z;
      points_pending.push_back(p);
   endtask

   task automatic push_corners;
      push_point(0, 0, 0);
      push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_point(32'h0001_0000, 0, 0);
      push_point(0, 32'hFFFF_0000, 0);
      push_point(0, 0, 1);
      push_point(cx_cfg, cy_cfg, 0);
      push_point(-cx_cfg, -cy_cfg, 0);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 0;
      push_corners();
      drain();
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: begin
               write_reg(RegShape, ShapeSphere);
               write_reg(RegScaleX, 16'hFFFF); write_reg(RegScaleY, 16'hFFFF);
               write_reg(RegScaleZ, 16'hFFFF);
               write_reg(RegEpsilon, 0);
               write_reg(RegCenterX, 32'h7FFF_FFFF); write_reg(RegCenterY, 32'h8000_0000);
            end
            1: begin
               write_reg(RegShape, ShapeBoxes);
               write_reg(RegScaleX, 1); write_reg(RegScaleY, 1); write_reg(RegScaleZ, 1);
               write_reg(RegEpsilon, 32'h7FFF_FFFF);
               write_reg(RegCenterX, 32'h8000_0000); write_reg(RegCenterY, 32'h7FFF_FFFF);
            end
            default: begin
               write_reg(RegShape, ph % 4 == 3 ? ShapeSpare : 2'(ph % 4));
               write_reg(RegScaleX, rand_scale()); write_reg(RegScaleY, rand_scale());
               write_reg(RegScaleZ, rand_scale());
               write_reg(RegEpsilon, rand_eps());
               write_reg(RegCenterX, rand_coord()); write_reg(RegCenterY, rand_coord());
            end
         endcase
         if (ph < 2) push_corners();
         for (int i = 0; i < 135; i++) begin
            if ($urandom_range(3) == 0)
               push_point(rand_coord() + cx_cfg, rand_coord() + cy_cfg, rand_coord());
            else
               push_point(rand_coord(), rand_coord(), rand_coord());
         end
         drain();
      end
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
